/* design/nntt_pkg.sv */
// Shared types, constants and codes for the nearest-neighbour track table.
// Used by nntt_scan, the core and the testbench; depends on nothing.
package nntt_pkg;

    localparam int TRACK_SLOTS_DEF = 8;
    localparam int SQ_W = 26;
    localparam int CFG_IDX_W = 2;

    localparam logic [12:0] HALF_TURN = 13'd2880;
    localparam logic signed [13:0] FULL_TURN = 14'sd5760;
    localparam logic [19:0] HITS_CAP = 20'd1000000;
    localparam logic [7:0] NUMBER_WRAP = 8'd250;

    localparam logic [CFG_IDX_W-1:0] CFG_HITS_TO_CONFIRM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MISS_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_DISTANCE = 2'd2;

    localparam logic [19:0] HITS_TO_CONFIRM_RST = 20'd3;
    localparam logic [31:0] MISS_TIMEOUT_RST = 32'd500;
    localparam logic [12:0] GATE_DISTANCE_RST = 13'd80;

    typedef enum logic [1:0] {
        OUT_NONE  = 2'd0,
        OUT_MATCH = 2'd1,
        OUT_NEW   = 2'd2,
        OUT_DROP  = 2'd3
    } outcome_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic [7:0]         number;
        logic [12:0]        azimuth;
        logic signed [11:0] elevation;
        logic [11:0]        size;
        logic [19:0]        hits;
        logic [31:0]        last_seen;
    } track_rec_t;

    typedef struct packed {
        logic        match_found;
        logic        free_found;
        logic [19:0] match_hits;
        logic [7:0]  match_number;
        logic        pipe_busy;
    } scan_status_t;

endpackage

/* design/nntt_ram.sv */
// Generic single-write, single-read memory with registered read data.
// No dependencies.
module nntt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/nntt_scan.sv */
// Scan pipeline: angular distance, gate test and age test per track record.
// Depends on nntt_pkg; fed by the track memory read port.
module nntt_scan
    import nntt_pkg::*;
#(
    parameter int TRACK_SLOTS = TRACK_SLOTS_DEF,
    localparam int IDX_W = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1,
    localparam int CNT_W = $clog2(TRACK_SLOTS + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    issue_valid,
    input  logic [IDX_W-1:0]        issue_idx,
    input  track_rec_t              rd_data,
    input  logic [TRACK_SLOTS-1:0]  slot_used,
    input  logic [12:0]             det_azimuth,
    input  logic signed [11:0]      det_elevation,
    input  logic [31:0]             now_ms,
    input  logic [31:0]             miss_timeout_ms,
    input  logic [SQ_W-1:0]         gate_sq,
    output scan_status_t            status,
    output logic [IDX_W-1:0]        match_idx,
    output logic [IDX_W-1:0]        free_idx,
    output logic [TRACK_SLOTS-1:0]  expire_vec,
    output logic [CNT_W-1:0]        expire_tally
);

    logic                   s0_valid_reg;
    logic [IDX_W-1:0]       s0_idx_reg;

    logic                   s1_valid_reg;
    logic [IDX_W-1:0]       s1_idx_reg;
    logic signed [13:0]     s1_daz_reg;
    logic [11:0]            s1_del_reg;
    logic [19:0]            s1_hits_reg;
    logic [7:0]             s1_number_reg;

    logic                   s2_valid_reg;
    logic [IDX_W-1:0]       s2_idx_reg;
    logic [SQ_W-1:0]        s2_sq_az_reg;
    logic [SQ_W-1:0]        s2_sq_el_reg;
    logic [19:0]            s2_hits_reg;
    logic [7:0]             s2_number_reg;

    logic [SQ_W-1:0]        best_sq_reg;
    logic                   match_found_reg;
    logic [IDX_W-1:0]       match_idx_reg;
    logic [19:0]            match_hits_reg;
    logic [7:0]             match_number_reg;
    logic                   free_found_reg;
    logic [IDX_W-1:0]       free_idx_reg;
    logic [TRACK_SLOTS-1:0] expire_vec_reg;
    logic [CNT_W-1:0]       tally_reg;

    logic [12:0]            az_abs;
    logic signed [13:0]     az_fold;
    logic signed [12:0]     el_diff;
    logic [11:0]            el_abs;
    logic [31:0]            age;
    logic                   aged;
    logic signed [27:0]     prod_az;
    logic [23:0]            prod_el;
    logic [SQ_W-1:0]        sum_sq;
    logic                   take_match;
    logic                   take_free;

    // Stage 1: fold azimuth difference, abs elevation difference, age test
    always_comb
    begin
        az_abs = (rd_data.azimuth >= det_azimuth) ? rd_data.azimuth - det_azimuth
                                                  : det_azimuth - rd_data.azimuth;
        if (az_abs > HALF_TURN)
        begin
            az_fold = FULL_TURN - $signed({1'b0, az_abs});
        end
        else
        begin
            az_fold = $signed({1'b0, az_abs});
        end
        el_diff = $signed({rd_data.elevation[11], rd_data.elevation})
                - $signed({det_elevation[11], det_elevation});
        el_abs = el_diff[12] ? 12'(-el_diff) : el_diff[11:0];
        age = now_ms - rd_data.last_seen;
        aged = slot_used[s0_idx_reg] && (age > miss_timeout_ms);
    end

    // Stage 2: squares
    assign prod_az = s1_daz_reg * s1_daz_reg;
    assign prod_el = s1_del_reg * s1_del_reg;

    // Stage 3: sum, gate compare against the running best, first free slot
    assign sum_sq = s2_sq_az_reg + s2_sq_el_reg;
    assign take_match = s2_valid_reg && slot_used[s2_idx_reg] && (sum_sq < best_sq_reg);
    assign take_free = s2_valid_reg && !slot_used[s2_idx_reg] && !free_found_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= issue_valid;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_idx_reg <= issue_idx;

        s1_idx_reg <= s0_idx_reg;
        s1_daz_reg <= az_fold;
        s1_del_reg <= el_abs;
        s1_hits_reg <= rd_data.hits;
        s1_number_reg <= rd_data.number;

        s2_idx_reg <= s1_idx_reg;
        s2_sq_az_reg <= prod_az[SQ_W-1:0];
        s2_sq_el_reg <= SQ_W'(prod_el);
        s2_hits_reg <= s1_hits_reg;
        s2_number_reg <= s1_number_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_sq_reg <= '0;
            match_found_reg <= 1'b0;
            match_idx_reg <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg <= '0;
            expire_vec_reg <= '0;
            tally_reg <= '0;
            match_hits_reg <= '0;
            match_number_reg <= '0;
        end
        else if (start)
        begin
            best_sq_reg <= gate_sq;
            match_found_reg <= 1'b0;
            free_found_reg <= 1'b0;
            expire_vec_reg <= '0;
            tally_reg <= '0;
        end
        else
        begin
            if (s0_valid_reg && aged)
            begin
                expire_vec_reg[s0_idx_reg] <= 1'b1;
                tally_reg <= tally_reg + CNT_W'(1);
            end
            if (take_match)
            begin
                best_sq_reg <= sum_sq;
                match_found_reg <= 1'b1;
                match_idx_reg <= s2_idx_reg;
                match_hits_reg <= s2_hits_reg;
                match_number_reg <= s2_number_reg;
            end
            if (take_free)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg <= s2_idx_reg;
            end
        end
    end

    always_comb
    begin
        status.match_found = match_found_reg;
        status.free_found = free_found_reg;
        status.match_hits = match_hits_reg;
        status.match_number = match_number_reg;
        status.pipe_busy = s0_valid_reg || s1_valid_reg || s2_valid_reg;
    end

    assign match_idx = match_idx_reg;
    assign free_idx = free_idx_reg;
    assign expire_vec = expire_vec_reg;
    assign expire_tally = tally_reg;

`ifndef SYNTHESIS
    a_match_is_used: assert property (@(posedge clk) disable iff (!rst_n)
        take_match |-> slot_used[s2_idx_reg])
        else $error("match taken on a free slot");

    a_best_within_gate: assert property (@(posedge clk) disable iff (!rst_n)
        take_match |=> best_sq_reg < $past(best_sq_reg))
        else $error("best distance did not shrink on a match");

    a_tally_bound: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(expire_vec_reg) == int'(tally_reg))
        else $error("expire tally disagrees with expire vector");
`endif

endmodule

/* design/nearest_neighbour_track_table_core.sv */
// Top level of the nearest-neighbour track table: sequencer, slot flags,
// configuration registers and result register. Depends on nntt_pkg,
// nntt_ram and nntt_scan.
//
// After an input beat is accepted, the track memory is read one slot per
// cycle through its single read port into a three-stage distance pipeline,
// then a commit state writes the matched or new track back and ages the
// table. The next beat is accepted in the cycle after the commit, while the
// result still waits in the output register, so beats are handled one at a
// time. A result left waiting holds the next commit. The memory needs no
// clearing pass after reset: per-slot used flags held in flip-flops decide
// which records count. Configuration writes are taken every cycle and
// belong between beats, while no beat is in flight.
module nearest_neighbour_track_table_core
    import nntt_pkg::*;
#(
    parameter int TRACK_SLOTS = TRACK_SLOTS_DEF,
    localparam int IDX_W = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1,
    localparam int CNT_W = $clog2(TRACK_SLOTS + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 has_detection,
    input  logic [12:0]          azimuth,
    input  logic signed [11:0]   elevation,
    input  logic [11:0]          target_size,
    input  logic [31:0]          now_ms,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           outcome,
    output logic [2:0]           slot,
    output logic [7:0]           track_number,
    output logic [19:0]          hit_count,
    output logic                 confirmed,
    output logic [3:0]           expired_count
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TRACK_SLOTS - 1);
    localparam int REC_W = $bits(track_rec_t);

    state_t                 state_reg;
    state_t                 state_next;
    logic [IDX_W-1:0]       issue_cnt_reg;
    logic [IDX_W-1:0]       issue_cnt_next;

    logic [19:0]            hits_to_confirm_reg;
    logic [31:0]            miss_timeout_reg;
    logic [12:0]            gate_distance_reg;
    logic [SQ_W-1:0]        gate_sq;

    logic                   item_det_reg;
    logic [12:0]            item_az_reg;
    logic signed [11:0]     item_el_reg;
    logic [11:0]            item_size_reg;
    logic [31:0]            item_now_reg;

    logic [TRACK_SLOTS-1:0] slot_used_reg;
    logic [TRACK_SLOTS-1:0] slot_used_next;
    logic [TRACK_SLOTS-1:0] slot_active_reg;
    logic [TRACK_SLOTS-1:0] slot_active_next;
    logic [7:0]             next_number_reg;
    logic [7:0]             next_number_next;

    logic                   out_valid_reg;
    outcome_t               outcome_reg;
    logic [2:0]             slot_reg;
    logic [7:0]             number_reg;
    logic [19:0]            hits_reg;
    logic                   confirmed_reg;
    logic [3:0]             expired_reg;

    outcome_t               outcome_next;
    logic [2:0]             slot_out_next;
    logic [7:0]             number_out_next;
    logic [19:0]            hits_out_next;
    logic                   confirmed_out_next;
    logic [3:0]             expired_out_next;

    logic                   in_accept;
    logic                   scan_start;
    logic                   issue_valid;
    logic                   commit_fire;
    logic                   ram_we;

    track_rec_t             rd_rec;
    track_rec_t             wr_rec;
    logic [REC_W-1:0]       rd_bits;

    scan_status_t           status;
    logic [IDX_W-1:0]       match_idx;
    logic [IDX_W-1:0]       free_idx;
    logic [TRACK_SLOTS-1:0] expire_vec;
    logic [CNT_W-1:0]       expire_tally;

    logic                   is_match;
    logic                   is_new;
    logic [IDX_W-1:0]       touch_idx;
    logic [TRACK_SLOTS-1:0] touch_vec;
    logic [TRACK_SLOTS-1:0] expire_eff;
    logic [CNT_W-1:0]       tally_fix;
    logic [CNT_W+3:0]       tally_ext;
    logic [IDX_W+2:0]       touch_ext;
    logic [19:0]            hits_new;
    logic                   active_new;

    // Configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hits_to_confirm_reg <= HITS_TO_CONFIRM_RST;
            miss_timeout_reg <= MISS_TIMEOUT_RST;
            gate_distance_reg <= GATE_DISTANCE_RST;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_HITS_TO_CONFIRM: hits_to_confirm_reg <= cfg_data[19:0];
                    CFG_MISS_TIMEOUT:    miss_timeout_reg <= cfg_data;
                    CFG_GATE_DISTANCE:   gate_distance_reg <= cfg_data[12:0];
                    default:             ;
                endcase
            end
        end
    end

    assign gate_sq = {{(SQ_W-13){1'b0}}, gate_distance_reg}
                   * {{(SQ_W-13){1'b0}}, gate_distance_reg};

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (issue_cnt_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        issue_valid = 1'b0;
        commit_fire = 1'b0;
        issue_cnt_next = issue_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                issue_cnt_next = '0;
            end
            ST_SCAN:
            begin
                issue_valid = 1'b1;
                issue_cnt_next = issue_cnt_reg + IDX_W'(1);
            end
            ST_DRAIN:   ;
            ST_COMMIT:  commit_fire = !out_valid_reg || out_ready;
            default:    ;
        endcase
    end

    assign in_accept = in_valid && in_ready;
    assign scan_start = in_accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            issue_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            issue_cnt_reg <= issue_cnt_next;
        end
    end

    // Hold the accepted beat
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_det_reg <= has_detection;
            item_az_reg <= azimuth;
            item_el_reg <= elevation;
            item_size_reg <= target_size;
            item_now_reg <= now_ms;
        end
    end

    // Track memory and scan pipeline
    nntt_ram #(
        .WIDTH (REC_W),
        .DEPTH (TRACK_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (touch_idx),
        .wdata (wr_rec),
        .re    (issue_valid),
        .raddr (issue_cnt_reg),
        .rdata (rd_bits)
    );

    assign rd_rec = track_rec_t'(rd_bits);

    nntt_scan #(
        .TRACK_SLOTS (TRACK_SLOTS)
    ) u_scan (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (scan_start),
        .issue_valid     (issue_valid),
        .issue_idx       (issue_cnt_reg),
        .rd_data         (rd_rec),
        .slot_used       (slot_used_reg),
        .det_azimuth     (item_az_reg),
        .det_elevation   (item_el_reg),
        .now_ms          (item_now_reg),
        .miss_timeout_ms (miss_timeout_reg),
        .gate_sq         (gate_sq),
        .status          (status),
        .match_idx       (match_idx),
        .free_idx        (free_idx),
        .expire_vec      (expire_vec),
        .expire_tally    (expire_tally)
    );

    // Commit: update the touched track, age the rest, build the result
    always_comb
    begin
        is_match = item_det_reg && status.match_found;
        is_new = item_det_reg && !status.match_found && status.free_found;
        touch_idx = is_match ? match_idx : free_idx;
        touch_vec = '0;
        if (is_match || is_new)
        begin
            touch_vec[touch_idx] = 1'b1;
        end
        expire_eff = expire_vec & ~touch_vec;
        tally_fix = expire_tally - CNT_W'(is_match && expire_vec[match_idx]);
        tally_ext = {4'b0, tally_fix};
        touch_ext = {3'b0, touch_idx};

        hits_new = (status.match_hits < HITS_CAP) ? status.match_hits + 20'd1
                                                  : status.match_hits;
        active_new = slot_active_reg[match_idx] || (hits_new >= hits_to_confirm_reg);

        wr_rec.azimuth = item_az_reg;
        wr_rec.elevation = item_el_reg;
        wr_rec.size = item_size_reg;
        wr_rec.last_seen = item_now_reg;
        wr_rec.number = is_match ? status.match_number : next_number_reg;
        wr_rec.hits = is_match ? hits_new : 20'd1;

        slot_used_next = (slot_used_reg & ~expire_eff) | (is_new ? touch_vec : '0);
        slot_active_next = slot_active_reg & ~expire_eff;
        if (is_match)
        begin
            slot_active_next[touch_idx] = active_new;
        end
        if (is_new)
        begin
            slot_active_next[touch_idx] = 1'b0;
        end
        next_number_next = next_number_reg;
        if (is_new)
        begin
            next_number_next = (next_number_reg >= NUMBER_WRAP) ? 8'd1
                                                                : next_number_reg + 8'd1;
        end

        outcome_next = OUT_NONE;
        slot_out_next = 3'd0;
        number_out_next = 8'd0;
        hits_out_next = 20'd0;
        confirmed_out_next = 1'b0;
        if (is_match)
        begin
            outcome_next = OUT_MATCH;
            slot_out_next = touch_ext[2:0];
            number_out_next = status.match_number;
            hits_out_next = hits_new;
            confirmed_out_next = active_new;
        end
        else if (is_new)
        begin
            outcome_next = OUT_NEW;
            slot_out_next = touch_ext[2:0];
            number_out_next = next_number_reg;
            hits_out_next = 20'd1;
        end
        else if (item_det_reg)
        begin
            outcome_next = OUT_DROP;
        end
        expired_out_next = (tally_ext > (CNT_W + 4)'(15)) ? 4'd15 : tally_ext[3:0];
    end

    assign ram_we = commit_fire && (is_match || is_new);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_used_reg <= '0;
            slot_active_reg <= '0;
            next_number_reg <= 8'd1;
        end
        else if (commit_fire)
        begin
            slot_used_reg <= slot_used_next;
            slot_active_reg <= slot_active_next;
            next_number_reg <= next_number_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit_fire)
        begin
            outcome_reg <= outcome_next;
            slot_reg <= slot_out_next;
            number_reg <= number_out_next;
            hits_reg <= hits_out_next;
            confirmed_reg <= confirmed_out_next;
            expired_reg <= expired_out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign outcome = outcome_reg;
    assign slot = slot_reg;
    assign track_number = number_reg;
    assign hit_count = hits_reg;
    assign confirmed = confirmed_reg;
    assign expired_count = expired_reg;

`ifndef SYNTHESIS
    a_active_needs_used: assert property (@(posedge clk) disable iff (!rst_n)
        (slot_active_reg & ~slot_used_reg) == '0)
        else $error("active flag set on a free slot");

    a_number_range: assert property (@(posedge clk) disable iff (!rst_n)
        next_number_reg != 8'd0 && next_number_reg <= NUMBER_WRAP)
        else $error("next track number out of range");

    a_commit_drained: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_COMMIT |-> !status.pipe_busy && !issue_valid)
        else $error("commit with scan pipeline still busy");

    a_match_slot_used: assert property (@(posedge clk) disable iff (!rst_n)
        commit_fire && is_match |-> slot_used_reg[match_idx])
        else $error("match committed to a free slot");

    a_new_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        commit_fire && is_new |=> slot_used_reg[$past(free_idx)])
        else $error("new track slot not marked used");
`endif

endmodule

/* sim/nearest_neighbour_track_table_core_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for nearest_neighbour_track_table_core: drives detection beats
// and register writes, predicts each track table result in step, checks every output beat.
// Depends on nntt_pkg and the core RTL.
module nearest_neighbour_track_table_core_tb;
    import nntt_pkg::*;

    localparam int SLOT_COUNT = TRACK_SLOTS_DEF;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = SLOT_COUNT + 10;

    typedef struct packed {
        logic               has_det;
        logic [12:0]        az;
        logic signed [11:0] el;
        logic [11:0]        size;
        logic [31:0]        now;
    } det_beat_t;

    typedef struct packed {
        outcome_t    outcome;
        logic [2:0]  slot;
        logic [7:0]  number;
        logic [19:0] hits;
        logic        confirmed;
        logic [3:0]  expired;
    } track_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic                 has_detection;
    logic [12:0]          azimuth;
    logic signed [11:0]   elevation;
    logic [11:0]          target_size;
    logic [31:0]          now_ms;
    logic                 out_valid;
    logic                 out_ready;
    logic [1:0]           outcome;
    logic [2:0]           slot;
    logic [7:0]           track_number;
    logic [19:0]          hit_count;
    logic                 confirmed;
    logic [3:0]           expired_count;

    nearest_neighbour_track_table_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .has_detection (has_detection),
        .azimuth       (azimuth),
        .elevation     (elevation),
        .target_size   (target_size),
        .now_ms        (now_ms),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .outcome       (outcome),
        .slot          (slot),
        .track_number  (track_number),
        .hit_count     (hit_count),
        .confirmed     (confirmed),
        .expired_count (expired_count)
    );

    logic [19:0] conf_hits;
    logic [31:0] conf_timeout;
    logic [12:0] conf_gate;

    bit          trk_used   [SLOT_COUNT];
    bit          trk_active [SLOT_COUNT];
    logic [7:0]  trk_id     [SLOT_COUNT];
    int          trk_az     [SLOT_COUNT];
    int          trk_el     [SLOT_COUNT];
    logic [11:0] trk_size   [SLOT_COUNT];
    logic [19:0] trk_hits   [SLOT_COUNT];
    logic [31:0] trk_seen   [SLOT_COUNT];
    logic [7:0]  next_id;

    track_result_t pending_results[$];

    int          send_idle_pct;
    int          recv_idle_pct;
    bit          out_hold_req;
    logic [31:0] stim_now;
    int          fail_count;
    int          beat_count;
    int          reg_writes;
    int          outcome_seen [4];
    int          aged_out;

    function automatic void clear_track(input int i);
        trk_used[i]   = 1'b0;
        trk_active[i] = 1'b0;
        trk_id[i]     = '0;
        trk_az[i]     = 0;
        trk_el[i]     = 0;
        trk_size[i]   = '0;
        trk_hits[i]   = '0;
        trk_seen[i]   = '0;
    endfunction

    function automatic track_result_t predict_track_update(input det_beat_t b);
        track_result_t r;
        int            best;
        int            daz;
        int            del;
        int            nexp;
        longint        best_sq;
        longint        sq;
        logic [31:0]   age;
        r    = '0;
        best = -1;
        nexp = 0;
        if (b.has_det) begin
            best_sq = longint'(conf_gate) * longint'(conf_gate);
            for (int i = 0; i < SLOT_COUNT; i++) begin
                if (trk_used[i]) begin
                    daz = trk_az[i] - int'(b.az);
                    if (daz < 0)
                        daz = -daz;
                    if (daz > int'(HALF_TURN))
                        daz = int'(FULL_TURN) - daz;
                    del = trk_el[i] - int'(b.el);
                    if (del < 0)
                        del = -del;
                    sq = longint'(daz) * daz + longint'(del) * del;
                    if (sq < best_sq)
                    begin
                        best_sq = sq;
                        best    = i;
                    end
                end
            end
            if (best >= 0)
            begin
                trk_az[best]   = int'(b.az);
                trk_el[best]   = int'(b.el);
                trk_size[best] = b.size;
                trk_seen[best] = b.now;
                if (trk_hits[best] < HITS_CAP)
                    trk_hits[best] = trk_hits[best] + 1'b1;
                if (trk_hits[best] >= conf_hits)
                    trk_active[best] = 1'b1;
                r.outcome = OUT_MATCH;
            end
            else
            begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (!trk_used[i] && best < 0)
                        best = i;
                end
                if (best >= 0)
                begin
                    trk_used[best]   = 1'b1;
                    trk_active[best] = 1'b0;
                    trk_id[best]     = next_id;
                    next_id          = (next_id == NUMBER_WRAP) ? 8'd1 : next_id + 8'd1;
                    trk_az[best]     = int'(b.az);
                    trk_el[best]     = int'(b.el);
                    trk_size[best]   = b.size;
                    trk_hits[best]   = 20'd1;
                    trk_seen[best]   = b.now;
                    r.outcome        = OUT_NEW;
                end
                else
                    r.outcome = OUT_DROP;
            end
            if (best >= 0)
            begin
                r.slot      = best[2:0];
                r.number    = trk_id[best];
                r.hits      = trk_hits[best];
                r.confirmed = trk_active[best];
            end
        end
        for (int i = 0; i < SLOT_COUNT; i++) begin
            age = b.now - trk_seen[i];
            if (trk_used[i] && age > conf_timeout)
            begin
                clear_track(i);
                nexp++;
            end
        end
        r.expired = (nexp > 15) ? 4'hF : nexp[3:0];
        return r;
    endfunction

    function automatic det_beat_t make_beat(input bit det, input int az, input int el,
                                            input int size, input logic [31:0] now);
        det_beat_t b;
        b.has_det = det;
        b.az      = az[12:0];
        b.el      = el[11:0];
        b.size    = size[11:0];
        b.now     = now;
        return b;
    endfunction

    function automatic det_beat_t next_random_beat();
        det_beat_t b;
        int        pick;
        int        k;
        int        span;
        int        az_i;
        int        el_i;
        pick = $urandom_range(99);
        if (pick < 3)
            stim_now = stim_now + $urandom;
        else if (pick < 9)
            stim_now = stim_now + conf_timeout + $urandom_range(1, 40);
        else
            stim_now = stim_now + $urandom_range(0, 30);
        b.now     = stim_now;
        b.has_det = ($urandom_range(99) >= 12);
        b.size    = 12'($urandom);
        k         = $urandom_range(SLOT_COUNT - 1);
        pick      = $urandom_range(99);
        if (pick < 65 && trk_used[k])
        begin
            span = ((conf_gate > 200) ? 200 : int'(conf_gate)) + 4;
            az_i = trk_az[k] + int'($urandom_range(2 * span)) - span + int'(FULL_TURN);
            az_i = az_i % int'(FULL_TURN);
            el_i = trk_el[k] + int'($urandom_range(2 * span)) - span;
            b.az = az_i[12:0];
            b.el = el_i[11:0];
        end
        else if (pick < 93)
        begin
            b.az = 13'($urandom_range(int'(FULL_TURN) - 1));
            b.el = 12'(int'($urandom_range(2880)) - 1440);
        end
        else
        begin
            b.az = 13'($urandom);
            b.el = 12'($urandom);
        end
        return b;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // hold off for a long stretch on request, else stall at random
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (out_hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                out_hold_req = 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        track_result_t got;
        track_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got.outcome   = outcome_t'(outcome);
            got.slot      = slot;
            got.number    = track_number;
            got.hits      = hit_count;
            got.confirmed = confirmed;
            got.expired   = expired_count;
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: unexpected result beat outcome=%0d slot=%0d", $realtime,
                             got.outcome, got.slot);
            end
            else
            begin
                want = pending_results.pop_front();
                outcome_seen[want.outcome]++;
                aged_out += want.expired;
                if (got !== want)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"%0t: mismatch exp outcome=%0d slot=%0d id=%0d hits=%0d ",
                                  "conf=%0d aged=%0d | got %0d %0d %0d %0d %0d %0d"},
                                 $realtime, want.outcome, want.slot, want.number, want.hits,
                                 want.confirmed, want.expired, got.outcome, got.slot,
                                 got.number, got.hits, got.confirmed, got.expired);
                end
            end
        end
    end

    task automatic send_detection(input det_beat_t b);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        has_detection <= b.has_det;
        azimuth       <= b.az;
        elevation     <= b.el;
        target_size   <= b.size;
        now_ms        <= b.now;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(predict_track_update(b));
        beat_count++;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_HITS_TO_CONFIRM: conf_hits    = value[19:0];
            CFG_MISS_TIMEOUT:    conf_timeout = value;
            CFG_GATE_DISTANCE:   conf_gate    = value[12:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(input logic [31:0] hits, input logic [31:0] timeout,
                                  input logic [31:0] gate);
        write_register(CFG_HITS_TO_CONFIRM, hits);
        write_register(CFG_MISS_TIMEOUT, timeout);
        write_register(CFG_GATE_DISTANCE, gate);
    endtask

    task automatic test_directed_cases();
        send_detection(make_beat(0, 0, 0, 0, 0));
        send_detection(make_beat(1, 0, 0, 0, 10));
        send_detection(make_beat(1, 5759, 0, 4095, 20));
        send_detection(make_beat(1, 5, 3, 100, 30));
        send_detection(make_beat(1, 2880, -1440, 1, 40));
        send_detection(make_beat(1, 2880, 1440, 2, 50));
        send_detection(make_beat(1, 1000, 0, 3, 60));
        send_detection(make_beat(1, 1100, 0, 4, 70));
        send_detection(make_beat(1, 1050, 0, 5, 80));
        send_detection(make_beat(1, 8191, 0, 6, 90));
        send_detection(make_beat(1, 100, -2048, 7, 100));
        send_detection(make_beat(1, 200, 2047, 8, 110));
        send_detection(make_beat(1, 4000, 0, 4095, 120));
        send_detection(make_beat(1, 8191, 0, 9, 130));
        send_detection(make_beat(0, 4095, -1, 4095, 700));
        send_detection(make_beat(1, 0, 0, 10, 32'hFFFF_FFF0));
        send_detection(make_beat(1, 10, 0, 11, 32'h0000_0100));
        send_detection(make_beat(0, 0, 0, 0, 32'h0000_0300));
        send_detection(make_beat(1, 0, 0, 12, 32'h0000_0310));
        send_detection(make_beat(1, 80, 0, 13, 32'h0000_0320));
        send_detection(make_beat(1, 79, 0, 14, 32'h0000_0330));
    endtask

    task automatic test_register_extremes();
        stim_now = 32'h0000_1000;
        apply_settings(1, 32'hFFFF_FFFF, 0);
        repeat (30) send_detection(next_random_beat());
        apply_settings(0, 0, 4096);
        repeat (30) send_detection(next_random_beat());
        apply_settings(HITS_CAP, 1000, 80);
        repeat (30) send_detection(next_random_beat());
    endtask

    task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                       input int beats);
        int pick;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        for (int i = 0; i < beats; i++)
        begin
            if (i % 130 == 0)
            begin
                pick = $urandom_range(9);
                apply_settings((pick == 0) ? $urandom_range(HITS_CAP) : $urandom_range(6),
                               (pick == 1) ? 32'hFFFF_FFFF : $urandom_range(60, 1500),
                               (pick == 2) ? $urandom_range(4096) : $urandom_range(8, 250));
            end
            send_detection(next_random_beat());
        end
    endtask

    task automatic test_output_backpressure();
        send_idle_pct = 0;
        out_hold_req  = 1'b1;
        repeat (12) send_detection(next_random_beat());
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        has_detection = 1'b0;
        azimuth       = '0;
        elevation     = '0;
        target_size   = '0;
        now_ms        = '0;
        out_hold_req  = 1'b0;
        send_idle_pct = 31;
        recv_idle_pct = 85;
        fail_count    = 0;
        beat_count    = 0;
        reg_writes    = 0;
        aged_out      = 0;
        stim_now      = '0;
        foreach (outcome_seen[i])
            outcome_seen[i] = 0;
        conf_hits    = HITS_TO_CONFIRM_RST;
        conf_timeout = MISS_TIMEOUT_RST;
        conf_gate    = GATE_DISTANCE_RST;
        next_id      = 8'd1;
        for (int i = 0; i < SLOT_COUNT; i++)
            clear_track(i);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_register_extremes();
        test_random_traffic(31, 85, 520);
        test_random_traffic(85, 31, 520);
        test_random_traffic(0, 0, 520);
        test_output_backpressure();

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run covered %0d beats: %0d ticks, %0d matched, %0d new, %0d dropped",
                 beat_count, outcome_seen[OUT_NONE], outcome_seen[OUT_MATCH],
                 outcome_seen[OUT_NEW], outcome_seen[OUT_DROP]);
        $display("%0d tracks aged out, %0d register writes, %0d failures",
                 aged_out, reg_writes, fail_count);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

/* sim.f */
design/nntt_pkg.sv
design/nntt_ram.sv
design/nntt_scan.sv
design/nearest_neighbour_track_table_core.sv
sim/nearest_neighbour_track_table_core_tb.sv
